// File: hdl/lzsswd_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and sequencer states for the LZSS window decompressor.
package lzsswd_pkg;

   localparam int WINDOW_SIZE_DEF = 4096;
   localparam int BYTE_W          = 8;
   localparam int LEN_W           = 25;
   localparam int CNT_W           = 24;
   localparam int TOK_POS_W       = 12;
   localparam int RUN_W           = 5;
   localparam int SYM_W           = 4;

   localparam logic [TOK_POS_W-1:0] POS_BIAS      = 12'd18;
   localparam logic [RUN_W-1:0]     MIN_MATCH     = 5'd3;
   localparam logic [SYM_W-1:0]     SYMS_PER_FLAG = 4'd8;
   localparam logic [LEN_W-1:0]     LEN_CAP       = 25'h100_0000;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_EMIT
   } seq_state_type;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } ring_ctl_type;

endpackage

// File: hdl/lzsswd_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for compressed input, decompressed output and length setup.
interface lzsswd_req_if;
   import lzsswd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] in_byte;
   modport source (output valid, output in_byte, input ready);
   modport sink (input valid, input in_byte, output ready);
endinterface

interface lzsswd_rsp_if;
   import lzsswd_pkg::*;
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] out_byte;
   logic              last_of_run;
   logic              stream_done;
   modport source (output valid, output out_byte, output last_of_run, output stream_done,
                   input ready);
   modport sink (input valid, input out_byte, input last_of_run, input stream_done,
                 output ready);
endinterface

interface lzsswd_csr_if;
   import lzsswd_pkg::*;
   logic             valid;
   logic             ready;
   logic [LEN_W-1:0] output_length;
   modport source (output valid, output output_length, input ready);
   modport sink (input valid, input output_length, output ready);
endinterface

// File: hdl/lzsswd_ring.sv
`timescale 1ns / 1ps
// History ring memory with registered read and a zero-fill sweep after reset.
module lzsswd_ring #(
   parameter int WINDOW_SIZE = lzsswd_pkg::WINDOW_SIZE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  lzsswd_pkg::ring_ctl_type           ctl,
   input  logic [$clog2(WINDOW_SIZE)-1:0]     wr_addr,
   input  logic [lzsswd_pkg::BYTE_W-1:0]      wr_data,
   input  logic [$clog2(WINDOW_SIZE)-1:0]     rd_addr,
   output logic [lzsswd_pkg::BYTE_W-1:0]      rd_data,
   output logic                               busy
);
   import lzsswd_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);

   logic [BYTE_W-1:0] mem [WINDOW_SIZE];
   logic              clearing_ff, clearing_in;
   logic [AW-1:0]     clr_addr_ff, clr_addr_in;
   logic [BYTE_W-1:0] rd_data_ff;
   logic              we;
   logic [AW-1:0]     waddr;
   logic [BYTE_W-1:0] wdata;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clearing_in = clearing_ff;
      if (clearing_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == {AW{1'b1}}) begin
            clearing_in = 1'b0;
         end
      end
   end

   // The sweep owns the write port until every entry holds zero.
   assign we    = clearing_ff | ctl.wr_en;
   assign waddr = clearing_ff ? clr_addr_ff : wr_addr;
   assign wdata = clearing_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
   assign busy    = clearing_ff;

endmodule

// File: hdl/lzsswd_window_decompressor_unit.sv
`timescale 1ns / 1ps
// Top level of the LZSS window decompressor: symbol decode, copy sequencer and output word.
// Flag and first token bytes are taken in idle; a literal moves to the emit state, which loads its word.
// A match alternates a ring read with the ring write and output load, one word per read and emit,
// the emit waiting while rsp_ch holds a word not yet taken; the next byte is taken once the run ends.
// After reset the ring is swept to zero with req_ch not ready, the sequencer state and counters
// are cleared and the output length is one.
module lzss_window_decompressor_unit #(
   parameter int WINDOW_SIZE = lzsswd_pkg::WINDOW_SIZE_DEF
) (
   input  logic          clock,
   input  logic          reset,
   lzsswd_req_if.sink    req_ch,
   lzsswd_rsp_if.source  rsp_ch,
   lzsswd_csr_if.sink    csr_ch
);
   import lzsswd_pkg::*;

   localparam int AW = $clog2(WINDOW_SIZE);

   seq_state_type     state_ff, state_in;
   logic [LEN_W-1:0]  out_len_ff, out_len_in;
   logic [AW-1:0]     wpos_ff, wpos_in;
   logic [BYTE_W-1:0] flag_ff, flag_in;
   logic [SYM_W-1:0]  left_ff, left_in;
   logic              phase_ff, phase_in;
   logic [BYTE_W-1:0] held_ff, held_in;
   logic [CNT_W-1:0]  emitted_ff, emitted_in;
   logic [AW-1:0]     rd_pos_ff, rd_pos_in;
   logic [RUN_W-1:0]  run_left_ff, run_left_in;
   logic              lit_ff, lit_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_done_ff, rsp_done_in;

   logic              ring_busy;
   ring_ctl_type      ring_ctl;
   logic [BYTE_W-1:0] ring_rd_data;
   logic [BYTE_W-1:0] emit_byte;

   logic                 req_go, csr_go, emit_go;
   logic                 take_flag, take_lit, take_hold, take_tok;
   logic [LEN_W-1:0]     eff_len, count;
   logic                 done, run_end, last;
   logic [TOK_POS_W-1:0] tok_pos;

   assign req_ch.ready = (state_ff == ST_IDLE) && !ring_busy;
   assign csr_ch.ready = 1'b1;
   assign req_go       = req_ch.valid && req_ch.ready;
   assign csr_go       = csr_ch.valid;

   assign take_flag = req_go && (left_ff == '0);
   assign take_lit  = req_go && (left_ff != '0) && flag_ff[0];
   assign take_hold = req_go && (left_ff != '0) && !flag_ff[0] && !phase_ff;
   assign take_tok  = req_go && (left_ff != '0) && !flag_ff[0] && phase_ff;

   assign tok_pos = {req_ch.in_byte[7:4], held_ff} + POS_BIAS;

   // A zero length counts as one; anything past the cap counts as the cap.
   always_comb begin
      priority if (out_len_ff == '0) begin
         eff_len = LEN_W'(1);
      end else if (out_len_ff > LEN_CAP) begin
         eff_len = LEN_CAP;
      end else begin
         eff_len = out_len_ff;
      end
   end

   assign emit_go   = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ch.ready);
   assign emit_byte = lit_ff ? byte_ff : ring_rd_data;
   assign count     = {1'b0, emitted_ff} + LEN_W'(1);
   assign done      = count >= eff_len;
   assign run_end   = lit_ff || (run_left_ff == RUN_W'(1));
   assign last      = run_end || done;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take_lit) begin
               state_in = ST_EMIT;
            end else if (take_tok) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_go) begin
               state_in = last ? ST_IDLE : ST_READ;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      out_len_in   = csr_go ? csr_ch.output_length : out_len_ff;
      wpos_in      = wpos_ff;
      flag_in      = flag_ff;
      left_in      = left_ff;
      phase_in     = phase_ff;
      held_in      = held_ff;
      emitted_in   = emitted_ff;
      rd_pos_in    = rd_pos_ff;
      run_left_in  = run_left_ff;
      lit_in       = lit_ff;
      byte_in      = byte_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_done_in  = rsp_done_ff;
      ring_ctl.rd_en = (state_ff == ST_READ);
      ring_ctl.wr_en = emit_go;

      if (take_flag) begin
         flag_in  = req_ch.in_byte;
         left_in  = SYMS_PER_FLAG;
         phase_in = 1'b0;
      end
      if (take_lit) begin
         byte_in = req_ch.in_byte;
         lit_in  = 1'b1;
      end
      if (take_hold) begin
         held_in  = req_ch.in_byte;
         phase_in = 1'b1;
      end
      if (take_tok) begin
         phase_in    = 1'b0;
         lit_in      = 1'b0;
         rd_pos_in   = AW'(tok_pos);
         run_left_in = {1'b0, req_ch.in_byte[3:0]} + MIN_MATCH;
      end

      if (emit_go) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_last_in  = last;
         rsp_done_in  = done;
         wpos_in      = wpos_ff + AW'(1);
         emitted_in   = count[CNT_W-1:0];
         run_left_in  = run_left_ff - RUN_W'(1);
         rd_pos_in    = rd_pos_ff + AW'(1);
         if (done) begin
            // End of stream: rewind the ring head and wait for a fresh flag byte.
            wpos_in    = '0;
            emitted_in = '0;
            left_in    = '0;
            phase_in   = 1'b0;
            flag_in    = '0;
         end else if (run_end) begin
            flag_in = {1'b0, flag_ff[BYTE_W-1:1]};
            left_in = left_ff - SYM_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_len_ff   <= LEN_W'(1);
         wpos_ff      <= '0;
         flag_ff      <= '0;
         left_ff      <= '0;
         phase_ff     <= 1'b0;
         held_ff      <= '0;
         emitted_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_len_ff   <= out_len_in;
         wpos_ff      <= wpos_in;
         flag_ff      <= flag_in;
         left_ff      <= left_in;
         phase_ff     <= phase_in;
         held_ff      <= held_in;
         emitted_ff   <= emitted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_pos_ff   <= rd_pos_in;
      run_left_ff <= run_left_in;
      lit_ff      <= lit_in;
      byte_ff     <= byte_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_done_ff <= rsp_done_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.out_byte    = rsp_byte_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;
   assign rsp_ch.stream_done = rsp_done_ff;

   lzsswd_ring #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .ctl     (ring_ctl),
      .wr_addr (wpos_ff),
      .wr_data (emit_byte),
      .rd_addr (rd_pos_ff),
      .rd_data (ring_rd_data),
      .busy    (ring_busy)
   );

endmodule
